// ----- hw/rtl/sc2k_pkg.sv -----
// Shared types, constants and key mapping tables for the scan code converter.
package sc2k_pkg;

   localparam int TABLE_SIZE = 89;
   localparam int TABLE_AW = 7;
   localparam int CODE_W = 8;
   localparam int ENTRY_W = 2 * CODE_W;
   localparam int SKIP_W = 3;
   localparam int PAUSE_SKIP_DEFAULT = 2;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [TABLE_AW-1:0] index_type;
   typedef logic [SKIP_W-1:0] skip_type;

   localparam code_type BYTE_PAUSE = 8'hE1;
   localparam code_type BYTE_PREFIX = 8'hE0;
   localparam code_type CODE_NONE = 8'h00;
   localparam code_type CODE_PAUSE = 8'hA0;
   localparam code_type CHAR_LOWER_A = 8'h61;
   localparam code_type CHAR_LOWER_Z = 8'h7A;

   localparam index_type IDX_LSHIFT = 7'd42;
   localparam index_type IDX_RSHIFT = 7'd54;
   localparam index_type IDX_CAPS = 7'd58;
   localparam index_type IDX_NUM = 7'd69;
   localparam index_type IDX_SCROLL = 7'd70;
   localparam index_type IDX_SYM_LO = 7'd2;
   localparam index_type IDX_SYM_HI = 7'd53;
   localparam index_type IDX_PAD_LO = 7'd71;
   localparam index_type IDX_PAD_HI = 7'd83;
   localparam index_type IDX_LAST = index_type'(TABLE_SIZE - 1);

   typedef struct packed {
      code_type shifted;
      code_type plain;
   } table_entry_type;

   typedef struct packed {
      logic en;
      index_type addr;
      table_entry_type data;
   } table_wr_type;

   typedef struct packed {
      logic valid;
      code_type scan_byte;
   } stage_type;

   localparam code_type PLAIN_CODE [TABLE_SIZE] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D,
      8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D,
      8'h0A, 8'h81, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
      8'h6C, 8'h3B, 8'h27, 8'h60,
      8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
      8'h2E, 8'h2F,
      8'h83, 8'h2A, 8'h85, 8'h20, 8'h86,
      8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
      8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99, 8'h9A,
      8'h9B, 8'h9C, 8'h9D,
      8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
   };

   localparam code_type SHIFTED_CODE [TABLE_SIZE] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B,
      8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D,
      8'h0A, 8'h81, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
      8'h4C, 8'h3A, 8'h22, 8'h7E,
      8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
      8'h3E, 8'h3F,
      8'h83, 8'h2A, 8'h85, 8'h20, 8'h86,
      8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
      8'h91, 8'h92,
      8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32,
      8'h33, 8'h30, 8'h2E,
      8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
   };

endpackage

// ----- hw/rtl/scan_code_to_key_converter_top.sv -----
// Top level of the set-1 scan code to key code converter.
// Takes one scan byte per cycle, once the mapping table is loaded and while rsp_ready does not
// hold back the result, and turns it into at most one key result: a byte passes the registered
// read of the table RAM and then the result register before rsp_valid. After reset the block
// copies all 89 table entries into the RAM, one entry a cycle, and holds req_ready low until done.
// Prefix byte E0 and bytes skipped after a pause byte produce no result transaction.
module scan_code_to_key_converter_top #(
   parameter int PAUSE_SKIP = sc2k_pkg::PAUSE_SKIP_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_key_code,
   output logic       rsp_key_pressed,
   output logic       rsp_key_extended,
   output logic [7:0] rsp_raw_code
);
   import sc2k_pkg::*;

   table_wr_type tbl_wr;
   table_entry_type entry;
   stage_type stage_ff, stage_in;
   logic fill_done;
   logic stage_ready;
   logic accept;
   index_type rd_addr;

   sc2k_table_fill u_fill (
      .clock     (clock),
      .reset     (reset),
      .tbl_wr    (tbl_wr),
      .fill_done (fill_done)
   );

   // Out-of-range indices read entry zero; the lookup stage substitutes the none code.
   assign rd_addr = (req_scan_byte[TABLE_AW-1:0] <= IDX_LAST) ?
                    req_scan_byte[TABLE_AW-1:0] : '0;

   sc2k_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   // The RAM read data only holds while no new read is issued, so a byte is taken only
   // when the lookup stage is empty or its byte moves on in the same cycle.
   assign req_ready = fill_done && (!stage_ff.valid || stage_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      stage_in.valid = accept || (stage_ff.valid && !stage_ready);
      stage_in.scan_byte = accept ? req_scan_byte : stage_ff.scan_byte;
   end

   always_ff @(posedge clock) begin
      stage_ff.scan_byte <= stage_in.scan_byte;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   sc2k_key_logic #(
      .PAUSE_SKIP (PAUSE_SKIP)
   ) u_key_logic (
      .clock            (clock),
      .reset            (reset),
      .stage            (stage_ff),
      .entry            (entry),
      .stage_ready      (stage_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_key_pressed  (rsp_key_pressed),
      .rsp_key_extended (rsp_key_extended),
      .rsp_raw_code     (rsp_raw_code)
   );

   a_stage_after_fill : assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> fill_done)
      else $error("lookup stage holds a byte before the table is loaded");

   a_result_from_stage : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage_ff.valid))
      else $error("result appeared without a byte in the lookup stage");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid && !stage_ready |=> stage_ff.valid && $stable(stage_ff.scan_byte))
      else $error("stalled byte in the lookup stage was lost or changed");

endmodule

// ----- hw/rtl/sc2k_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sc2k_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sc2k_table_fill.sv -----
// Sequencer that loads the key mapping table into the RAM after reset.
module sc2k_table_fill (
   input  logic                  clock,
   input  logic                  reset,
   output sc2k_pkg::table_wr_type tbl_wr,
   output logic                  fill_done
);
   import sc2k_pkg::*;

   index_type fill_ptr_ff, fill_ptr_in;
   logic fill_done_ff, fill_done_in;

   always_comb begin
      fill_ptr_in = fill_ptr_ff;
      fill_done_in = fill_done_ff;
      if (!fill_done_ff) begin
         if (fill_ptr_ff == IDX_LAST) begin
            fill_done_in = 1'b1;
         end else begin
            fill_ptr_in = fill_ptr_ff + index_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ptr_ff <= '0;
         fill_done_ff <= 1'b0;
      end else begin
         fill_ptr_ff <= fill_ptr_in;
         fill_done_ff <= fill_done_in;
      end
   end

   assign tbl_wr.en = !fill_done_ff;
   assign tbl_wr.addr = fill_ptr_ff;
   assign tbl_wr.data.plain = PLAIN_CODE[fill_ptr_ff];
   assign tbl_wr.data.shifted = SHIFTED_CODE[fill_ptr_ff];
   assign fill_done = fill_done_ff;

endmodule

// ----- hw/rtl/sc2k_key_logic.sv -----
// Lookup stage: modifier and lock flags, prefix and skip handling, result register.
module sc2k_key_logic #(
   parameter int PAUSE_SKIP = sc2k_pkg::PAUSE_SKIP_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sc2k_pkg::stage_type      stage,
   input  sc2k_pkg::table_entry_type entry,
   output logic                     stage_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_key_code,
   output logic                     rsp_key_pressed,
   output logic                     rsp_key_extended,
   output logic [7:0]               rsp_raw_code
);
   import sc2k_pkg::*;

   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic num_ff, num_in;
   logic scroll_ff, scroll_in;
   logic prefix_ff, prefix_in;
   skip_type skip_ff, skip_in;
   logic rsp_valid_ff, rsp_valid_in;
   code_type key_code_ff, key_code_in;
   logic pressed_ff, pressed_in;
   logic extended_ff, extended_in;
   code_type raw_ff, raw_in;

   index_type idx;
   logic down;
   logic in_table;
   logic is_letter;
   logic use_shifted;
   logic fire;

   assign stage_ready = !rsp_valid_ff || rsp_ready;
   assign fire = stage.valid && stage_ready;
   assign idx = stage.scan_byte[TABLE_AW-1:0];
   assign down = !stage.scan_byte[CODE_W-1];
   assign in_table = idx <= IDX_LAST;

   always_comb begin
      is_letter = in_table && (entry.plain inside {[CHAR_LOWER_A:CHAR_LOWER_Z]});
      if (is_letter) begin
         use_shifted = shift_ff ^ caps_ff;
      end else if (idx inside {[IDX_SYM_LO:IDX_SYM_HI]}) begin
         use_shifted = shift_ff;
      end else if (idx inside {[IDX_PAD_LO:IDX_PAD_HI]}) begin
         use_shifted = num_ff;
      end else begin
         use_shifted = 1'b0;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      caps_in = caps_ff;
      num_in = num_ff;
      scroll_in = scroll_ff;
      prefix_in = prefix_ff;
      skip_in = skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_code_in = key_code_ff;
      pressed_in = pressed_ff;
      extended_in = extended_ff;
      raw_in = raw_ff;
      if (fire) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - skip_type'(1);
         end else if (stage.scan_byte == BYTE_PAUSE) begin
            skip_in = skip_type'(PAUSE_SKIP);
            rsp_valid_in = 1'b1;
            key_code_in = CODE_PAUSE;
            pressed_in = 1'b1;
            extended_in = 1'b0;
            raw_in = stage.scan_byte;
         end else if (stage.scan_byte == BYTE_PREFIX) begin
            prefix_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            if (!in_table) begin
               key_code_in = CODE_NONE;
            end else if (use_shifted) begin
               key_code_in = entry.shifted;
            end else begin
               key_code_in = entry.plain;
            end
            pressed_in = down;
            extended_in = prefix_ff;
            raw_in = stage.scan_byte;
            prefix_in = 1'b0;
            if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
               shift_in = down;
            end else if (idx == IDX_CAPS && down) begin
               caps_in = !caps_ff;
            end else if (idx == IDX_NUM && down) begin
               num_in = !num_ff;
            end else if (idx == IDX_SCROLL && down) begin
               scroll_in = !scroll_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff <= 1'b0;
         num_ff <= 1'b0;
         scroll_ff <= 1'b0;
         prefix_ff <= 1'b0;
         skip_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         caps_ff <= caps_in;
         num_ff <= num_in;
         scroll_ff <= scroll_in;
         prefix_ff <= prefix_in;
         skip_ff <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_code_ff <= key_code_in;
      pressed_ff <= pressed_in;
      extended_ff <= extended_in;
      raw_ff <= raw_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key_code = key_code_ff;
   assign rsp_key_pressed = pressed_ff;
   assign rsp_key_extended = extended_ff;
   assign rsp_raw_code = raw_ff;

endmodule
